[sv/hdu_pkg.sv]
// Shared constants, word types and an arctangent helper function for the haversine distance unit.
`timescale 1ns / 1ps
`default_nettype none
package hdu_pkg;

    localparam int FRAC_BITS     = 20;
    localparam int CORDIC_STAGES = 24;
    localparam int DIV_DIGITS    = 8;
    localparam int DIV_CELLS     = 5;
    localparam int NUM_W         = DIV_DIGITS * DIV_CELLS;
    localparam int SQRT_CELLS    = 31;
    localparam int XY_W          = 34;
    localparam int ANG_W         = 36;
    localparam int PIPE_LEN      = 3 + DIV_CELLS + 2 + CORDIC_STAGES + 4 + SQRT_CELLS
                                   + CORDIC_STAGES + 1;

    localparam logic [6:0]  DIV_BY  = 7'd45;
    localparam logic [29:0] PI28    = 30'd843314857;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0]  CORDIC_K    = 34'sd652032874;
    localparam logic [30:0] Q_ONE   = 31'd1073741824;
    localparam logic signed [27:0] LAT_LIM = 28'(90 <<< FRAC_BITS);
    localparam logic signed [28:0] LON_LIM = 29'(180 <<< FRAC_BITS);
    localparam logic [60:0] RND_HALF_ANG = 61'(45) << FRAC_BITS;
    localparam logic [60:0] RND_FULL_ANG = 61'(45) << (FRAC_BITS - 1);
    localparam logic [22:0] RADIUS_RST   = 23'd6371000;

    localparam logic [30:0] ATAN_HEAD [10] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
        31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149
    };

    typedef struct packed {
        logic [NUM_W-1:0] n;
        logic [5:0]       r;
        logic [NUM_W-1:0] q;
        logic             neg;
    } div_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
        logic                   neg;
    } rot_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [61:0] v;
        logic [33:0] rem;
        logic [30:0] root;
    } sqrt_t;

    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        logic [30:0] res;
        if (i < 5'd10) begin
            res = ATAN_HEAD[i[3:0]];
        end else if (i < 5'd30) begin
            res = (31'd1 << (5'd30 - i)) - 31'd1;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/hdu_div_cell.sv]
// Divide-by-45 cell: eight quotient bits per stage of a long division.
`timescale 1ns / 1ps
`default_nettype none
module hdu_div_cell (
    input  wire logic          aclk,
    input  wire logic          en,
    input  hdu_pkg::div_t      d_in,
    output hdu_pkg::div_t      d_out
);
    hdu_pkg::div_t d_reg;
    hdu_pkg::div_t d_next;

    always_comb begin
        logic [6:0] t;
        d_next = d_in;
        for (int j = 0; j < hdu_pkg::DIV_DIGITS; j++) begin
            t = {d_next.r, d_next.n[hdu_pkg::NUM_W-1]};
            d_next.n = {d_next.n[hdu_pkg::NUM_W-2:0], 1'b0};
            if (t >= hdu_pkg::DIV_BY) begin
                d_next.r = 6'(t - hdu_pkg::DIV_BY);
                d_next.q = {d_next.q[hdu_pkg::NUM_W-2:0], 1'b1};
            end else begin
                d_next.r = t[5:0];
                d_next.q = {d_next.q[hdu_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[sv/hdu_rot_cell.sv]
// Rotation-mode CORDIC cell: one micro-rotation per stage.
`timescale 1ns / 1ps
`default_nettype none
module hdu_rot_cell (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [4:0]    shift,
    input  hdu_pkg::rot_t      d_in,
    output hdu_pkg::rot_t      d_out
);
    hdu_pkg::rot_t d_reg;
    hdu_pkg::rot_t d_next;
    logic signed [hdu_pkg::XY_W-1:0] dx, dy, at;

    always_comb begin
        dx = d_in.y >>> shift;
        dy = d_in.x >>> shift;
        at = $signed({3'b000, hdu_pkg::atan_q30(shift)});
        d_next = d_in;
        if (d_in.z >= 0) begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - at;
        end else begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[sv/hdu_sqrt_cell.sv]
// Integer square root cell: one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module hdu_sqrt_cell (
    input  wire logic          aclk,
    input  wire logic          en,
    input  hdu_pkg::sqrt_t     d_in,
    output hdu_pkg::sqrt_t     d_out
);
    hdu_pkg::sqrt_t d_reg;
    hdu_pkg::sqrt_t d_next;
    logic [33:0] rem2, trial;

    always_comb begin
        rem2  = {d_in.rem[31:0], d_in.v[61:60]};
        trial = {1'b0, d_in.root, 2'b01};
        d_next.v = {d_in.v[59:0], 2'b00};
        if (rem2 >= trial) begin
            d_next.rem  = rem2 - trial;
            d_next.root = {d_in.root[29:0], 1'b1};
        end else begin
            d_next.rem  = rem2;
            d_next.root = {d_in.root[29:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[sv/hdu_vec_cell.sv]
// Vectoring-mode CORDIC cell: one micro-rotation towards the x axis per stage.
`timescale 1ns / 1ps
`default_nettype none
module hdu_vec_cell (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [4:0]    shift,
    input  hdu_pkg::vec_t      d_in,
    output hdu_pkg::vec_t      d_out
);
    hdu_pkg::vec_t d_reg;
    hdu_pkg::vec_t d_next;
    logic signed [hdu_pkg::XY_W-1:0] dx, dy, at;

    always_comb begin
        dx = d_in.y >>> shift;
        dy = d_in.x >>> shift;
        at = $signed({3'b000, hdu_pkg::atan_q30(shift)});
        if (d_in.y > 0) begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + at;
        end else begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

[sv/haversine_distance_unit.sv]
// Top level of the pipelined haversine great-circle distance unit.
//
//  channel | dir | handshake        | word
//  s_      | in  | s_tvalid/tready  | tdata: lat_a, lon_a, lat_b, lon_b
//  m_      | out | m_tvalid/tready  | tdata: distance_m; tuser: range_error
//  cfg_    | in  | cfg_valid/ready  | cfg_data: sphere_radius_m
//
// One word per cycle while the output is not stalled; the pipeline runs through the
// divide-by-45 cells, the 24-cell sine/cosine chains, the 31-cell root chains and the
// 24-cell arctangent chain. Synchronous active-low reset clears the valid chain, the
// output and skid valid flags and restores the radius. A stalled output fills the skid
// register, after which s_tready drops and the whole chain holds.
`timescale 1ns / 1ps
`default_nettype none
module haversine_distance_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,   // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // distance_m[24:0]
    output logic              m_tuser,   // range_error[0]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [22:0]  cfg_data
);
    localparam int PL = hdu_pkg::PIPE_LEN;
    localparam int NC = hdu_pkg::CORDIC_STAGES;
    localparam int ND = hdu_pkg::DIV_CELLS;
    localparam int NS = hdu_pkg::SQRT_CELLS;
    localparam int XW = hdu_pkg::XY_W;

    logic signed [27:0] lat_a, lat_b;
    logic signed [28:0] lon_a, lon_b;
    logic signed [29:0] dsel [4];
    logic               err_in, s_acc, adv;

    logic [PL-1:0] vld_reg, err_reg;
    logic [22:0]   radius_reg;

    logic [29:0]          du_reg   [4];
    logic                 dneg_reg [4];
    logic [59:0]          prod_reg [4];
    logic                 pneg_reg [4];
    logic [hdu_pkg::NUM_W-1:0] num_reg [4];
    logic                 nneg_reg [4];
    logic signed [hdu_pkg::ANG_W-1:0] ang_reg [4];
    hdu_pkg::rot_t        rot0_reg [4];

    hdu_pkg::div_t  div_s  [4][ND+1];
    hdu_pkg::rot_t  rot_s  [4][NC+1];
    hdu_pkg::sqrt_t sqrt_s [2][NS+1];
    hdu_pkg::vec_t  vec_s  [NC+1];

    logic signed [31:0] sdl_reg, sdo_reg, c1_reg, c2_reg;
    logic signed [31:0] t1_reg, c12_reg, sq_reg, t1d_reg, t2_reg;
    logic [30:0]        a_reg, b_reg;
    logic [31:0]        c_reg;

    logic signed [63:0] p_t1, p_c12, p_sq, p_t2;
    logic signed [32:0] a_sum;
    logic [30:0]        a_next;
    logic signed [XW-1:0] zf;
    logic [55:0]        dist_prod;
    logic [24:0]        dist_next;

    logic        m_vld_reg, skid_vld_reg;
    logic [24:0] m_dist_reg, skid_dist_reg;
    logic        m_err_reg, skid_err_reg;

    assign lat_a = s_tdata[27:0];
    assign lon_a = s_tdata[56:28];
    assign lat_b = s_tdata[84:57];
    assign lon_b = s_tdata[113:85];

    assign err_in = (lat_a < -hdu_pkg::LAT_LIM) || (lat_a > hdu_pkg::LAT_LIM) ||
                    (lat_b < -hdu_pkg::LAT_LIM) || (lat_b > hdu_pkg::LAT_LIM) ||
                    (lon_a < -hdu_pkg::LON_LIM) || (lon_a > hdu_pkg::LON_LIM) ||
                    (lon_b < -hdu_pkg::LON_LIM) || (lon_b > hdu_pkg::LON_LIM);

    assign dsel[0] = 30'(lat_b) - 30'(lat_a);
    assign dsel[1] = 30'(lon_b) - 30'(lon_a);
    assign dsel[2] = 30'(lat_a);
    assign dsel[3] = 30'(lat_b);

    assign adv      = !skid_vld_reg;
    assign s_tready = adv;
    assign s_acc    = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            err_reg    <= '0;
            radius_reg <= hdu_pkg::RADIUS_RST;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[PL-2:0], s_acc};
                err_reg <= {err_reg[PL-2:0], err_in};
            end
            if (cfg_valid) begin
                radius_reg <= cfg_data;
            end
        end
    end

    // angle lanes: half dlat, half dlon, lat_a, lat_b
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [60:0] rnd_sum;
        logic signed [hdu_pkg::ANG_W-1:0] r1, r2;
        logic fneg;

        assign rnd_sum = {1'b0, prod_reg[l]} +
                         ((l < 2) ? hdu_pkg::RND_HALF_ANG : hdu_pkg::RND_FULL_ANG);

        always_comb begin
            r1 = ang_reg[l];
            fneg = 1'b0;
            if (r1 > hdu_pkg::PI_Q30) begin
                r1 = r1 - hdu_pkg::TWO_PI_Q30;
            end else if (r1 < -hdu_pkg::PI_Q30) begin
                r1 = r1 + hdu_pkg::TWO_PI_Q30;
            end
            r2 = r1;
            if (r1 > hdu_pkg::HALF_PI_Q30) begin
                r2 = hdu_pkg::PI_Q30 - r1;
                fneg = 1'b1;
            end else if (r1 < -hdu_pkg::HALF_PI_Q30) begin
                r2 = -hdu_pkg::PI_Q30 - r1;
                fneg = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                du_reg[l]   <= dsel[l][29] ? 30'(-dsel[l]) : dsel[l];
                dneg_reg[l] <= dsel[l][29];
                prod_reg[l] <= {30'b0, du_reg[l]} * {30'b0, hdu_pkg::PI28};
                pneg_reg[l] <= dneg_reg[l];
                num_reg[l]  <= (l < 2) ? hdu_pkg::NUM_W'(rnd_sum >> (hdu_pkg::FRAC_BITS + 1))
                                       : hdu_pkg::NUM_W'(rnd_sum >> hdu_pkg::FRAC_BITS);
                nneg_reg[l] <= pneg_reg[l];
                ang_reg[l]  <= div_s[l][ND].neg
                             ? -$signed(hdu_pkg::ANG_W'(div_s[l][ND].q))
                             :  $signed(hdu_pkg::ANG_W'(div_s[l][ND].q));
                rot0_reg[l].x   <= hdu_pkg::CORDIC_K;
                rot0_reg[l].y   <= '0;
                rot0_reg[l].z   <= XW'(r2);
                rot0_reg[l].neg <= fneg;
            end
        end

        assign div_s[l][0] = '{n: num_reg[l], r: '0, q: '0, neg: nneg_reg[l]};
        for (genvar k = 0; k < ND; k++) begin : g_div
            hdu_div_cell u_div (
                .aclk (aclk), .en (adv), .d_in (div_s[l][k]), .d_out (div_s[l][k+1])
            );
        end

        assign rot_s[l][0] = rot0_reg[l];
        for (genvar k = 0; k < NC; k++) begin : g_rot
            hdu_rot_cell u_rot (
                .aclk (aclk), .en (adv), .shift (5'(k)),
                .d_in (rot_s[l][k]), .d_out (rot_s[l][k+1])
            );
        end
    end

    assign p_t1  = 64'(sdl_reg) * 64'(sdl_reg);
    assign p_c12 = 64'(c1_reg) * 64'(c2_reg);
    assign p_sq  = 64'(sdo_reg) * 64'(sdo_reg);
    assign p_t2  = 64'(c12_reg) * 64'(sq_reg);
    assign a_sum = 33'(t1d_reg) + 33'(t2_reg);

    always_comb begin
        if (a_sum < 0) begin
            a_next = '0;
        end else if (a_sum > $signed({2'b00, hdu_pkg::Q_ONE})) begin
            a_next = hdu_pkg::Q_ONE;
        end else begin
            a_next = a_sum[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sdl_reg <= rot_s[0][NC].y[31:0];
            sdo_reg <= rot_s[1][NC].y[31:0];
            c1_reg  <= rot_s[2][NC].neg ? 32'(-rot_s[2][NC].x) : rot_s[2][NC].x[31:0];
            c2_reg  <= rot_s[3][NC].neg ? 32'(-rot_s[3][NC].x) : rot_s[3][NC].x[31:0];
            t1_reg  <= p_t1[61:30];
            c12_reg <= p_c12[61:30];
            sq_reg  <= p_sq[61:30];
            t1d_reg <= t1_reg;
            t2_reg  <= p_t2[61:30];
            a_reg   <= a_next;
            b_reg   <= hdu_pkg::Q_ONE - a_next;
        end
    end

    assign sqrt_s[0][0] = '{v: {1'b0, a_reg, 30'b0}, rem: '0, root: '0};
    assign sqrt_s[1][0] = '{v: {1'b0, b_reg, 30'b0}, rem: '0, root: '0};
    for (genvar l = 0; l < 2; l++) begin : g_sq
        for (genvar k = 0; k < NS; k++) begin : g_cell
            hdu_sqrt_cell u_sqrt (
                .aclk (aclk), .en (adv), .d_in (sqrt_s[l][k]), .d_out (sqrt_s[l][k+1])
            );
        end
    end

    assign vec_s[0] = '{x: $signed(XW'(sqrt_s[1][NS].root)),
                        y: $signed(XW'(sqrt_s[0][NS].root)), z: '0};
    for (genvar k = 0; k < NC; k++) begin : g_vec
        hdu_vec_cell u_vec (
            .aclk (aclk), .en (adv), .shift (5'(k)), .d_in (vec_s[k]), .d_out (vec_s[k+1])
        );
    end

    assign zf = vec_s[NC].z;
    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg <= (zf < 0) ? 32'd0 : {zf[30:0], 1'b0};
        end
    end

    assign dist_prod = ({33'b0, radius_reg} * {24'b0, c_reg}) + (56'd1 << 29);
    assign dist_next = dist_prod[54:30];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (adv) begin
            if (vld_reg[PL-1]) begin
                if (!m_vld_reg || m_tready) begin
                    m_vld_reg  <= 1'b1;
                    m_dist_reg <= dist_next;
                    m_err_reg  <= err_reg[PL-1];
                end else begin
                    skid_vld_reg  <= 1'b1;
                    skid_dist_reg <= dist_next;
                    skid_err_reg  <= err_reg[PL-1];
                end
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end else if (m_tready) begin
            m_dist_reg   <= skid_dist_reg;
            m_err_reg    <= skid_err_reg;
            skid_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {7'b0, m_dist_reg};
    assign m_tuser  = m_err_reg;
endmodule
`default_nettype wire

[sv/hdu_checker.sv]
// Port-level checks for the haversine distance unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hdu_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_rst_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("distance padding bits set");
endmodule

bind haversine_distance_unit hdu_checker u_hdu_checker (.*);
`default_nettype wire

[tb/tb_haversine_distance_unit.sv]
// Self-checking testbench for the haversine distance unit: directed table, then random words.
`timescale 1ns / 1ps
module tb_haversine_distance_unit;

    localparam int LAT90  = 90 << 20;
    localparam int LON180 = 180 << 20;
    localparam longint PI_RAD28 = 843314857;
    localparam longint PI_RAD   = 64'sd3373259426;
    localparam longint HPI_RAD  = 1686629713;
    localparam longint TWOPI_RAD = 64'sd6746518852;
    localparam longint GAIN_INV = 652032874;
    localparam longint ONE_Q30  = longint'(1) << 30;
    localparam int NUM_ROWS = 22;

    typedef struct packed {
        logic signed [27:0] lat_a;
        logic signed [28:0] lon_a;
        logic signed [27:0] lat_b;
        logic signed [28:0] lon_b;
        logic               bad;
    } coord_row_t;

    typedef struct packed {
        logic [24:0] dist_m;
        logic        bad;
    } distance_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [22:0]  cfg_data;

    logic [22:0]  radius_m;
    distance_t    pending_dist[$];
    coord_row_t   dir_rows[NUM_ROWS];
    logic         row_bad_q[$];
    logic         use_row_bad;
    int           errors;
    int           words_in;
    int           words_out;
    int           bad_seen;
    int           radii_used;
    logic         hold_done;

    longint arctan_head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                                33543515, 16775850, 8388437, 4194282, 2097149};

    haversine_distance_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic longint arctan_step(input int i);
        longint res;
        if (i < 10) res = arctan_head[i];
        else if (i < 30) res = (longint'(1) << (30 - i)) - 1;
        else res = 0;
        return res;
    endfunction

    // degrees * 2^20 to radians Q30, rounded half away from zero
    function automatic longint deg_to_rad(input longint deg, input longint div);
        longint num;
        longint unsigned den;
        longint unsigned mag;
        longint q;
        num = deg * PI_RAD28;
        den = longint'(div) << 18;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    task automatic sin_cos(input longint ang, output longint sn, output longint cs);
        longint r, x, y, z, dx, dy;
        logic flip;
        r = ang % TWOPI_RAD;
        x = GAIN_INV;
        y = 0;
        flip = 1'b0;
        if (r > PI_RAD) r -= TWOPI_RAD;
        if (r < -PI_RAD) r += TWOPI_RAD;
        if (r > HPI_RAD) begin
            r = PI_RAD - r;
            flip = 1'b1;
        end else if (r < -HPI_RAD) begin
            r = -PI_RAD - r;
            flip = 1'b1;
        end
        z = r;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endtask

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint arc_tan2(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        return z;
    endfunction

    task automatic predict_distance(input logic [119:0] w, input logic [22:0] rad,
                                    output distance_t res);
        longint la, oa, lb, ob;
        longint s_dlat, c_dlat, s_dlon, c_dlon, s1, c1, s2, c2;
        longint t1, c12, t2, a, c;
        longint unsigned sa, sb, prod;
        la = longint'($signed(w[27:0]));
        oa = longint'($signed(w[56:28]));
        lb = longint'($signed(w[84:57]));
        ob = longint'($signed(w[113:85]));
        res.bad = la < -LAT90 || la > LAT90 || lb < -LAT90 || lb > LAT90 ||
                  oa < -LON180 || oa > LON180 || ob < -LON180 || ob > LON180;
        sin_cos(deg_to_rad(lb - la, 360), s_dlat, c_dlat);
        sin_cos(deg_to_rad(ob - oa, 360), s_dlon, c_dlon);
        sin_cos(deg_to_rad(la, 180), s1, c1);
        sin_cos(deg_to_rad(lb, 180), s2, c2);
        t1 = (s_dlat * s_dlat) >>> 30;
        c12 = (c1 * c2) >>> 30;
        t2 = (c12 * ((s_dlon * s_dlon) >>> 30)) >>> 30;
        a = t1 + t2;
        if (a < 0) a = 0;
        if (a > ONE_Q30) a = ONE_Q30;
        sa = root_floor(longint'(a) << 30);
        sb = root_floor(longint'(ONE_Q30 - a) << 30);
        c = 2 * arc_tan2(sa, sb);
        if (c < 0) c = 0;
        prod = (longint'(rad) * c + (longint'(1) << 29)) >> 30;
        res.dist_m = prod[24:0];
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d (result %0d)", what, got, want, words_out);
        errors++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // acceptance-side prediction and result checking
    always @(posedge aclk) begin
        distance_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) radius_m <= cfg_data;
            if (s_tvalid && s_tready) begin
                predict_distance(s_tdata, radius_m, want);
                if (use_row_bad) want.bad = row_bad_q.pop_front();
                pending_dist.push_back(want);
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_dist.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[24:0], -1);
                end else begin
                    want = pending_dist.pop_front();
                    if (m_tdata[24:0] !== want.dist_m)
                        report_mismatch("distance_m", m_tdata[24:0], want.dist_m);
                    if (m_tuser !== want.bad)
                        report_mismatch("range_error", m_tuser, want.bad);
                end
                if (m_tuser === 1'b1) bad_seen++;
                words_out++;
            end
        end
    end

    // receiver: changing stall pattern, plus one long hold-off
    initial begin
        int mode, hold_left;
        mode = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (($urandom() & 63) == 0) mode = $urandom_range(0, 2);
            if (!hold_done && words_out >= 300) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic signed [27:0] la, input logic signed [28:0] oa,
                             input logic signed [27:0] lb, input logic signed [28:0] ob);
        if (($urandom() & 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, ob, lb, oa, la};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (110) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [22:0] r);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        radii_used++;
    endtask

    function automatic logic signed [27:0] pick_lat();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return 28'($urandom());
        if (k == 1) return 28'($urandom_range(0, 1) ? LAT90 : -LAT90);
        return 28'(int'($urandom_range(0, 2 * LAT90)) - LAT90);
    endfunction

    function automatic logic signed [28:0] pick_lon();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return 29'($urandom());
        if (k == 1) return 29'($urandom_range(0, 1) ? LON180 : -LON180);
        return 29'(int'($urandom_range(0, 2 * LON180)) - LON180);
    endfunction

    task automatic random_words(input int n);
        logic signed [27:0] la;
        logic signed [28:0] oa;
        la = pick_lat();
        oa = pick_lon();
        for (int i = 0; i < n; i++) begin
            // some pairs sit close together for short distances
            if ($urandom_range(0, 5) == 0)
                send_word(la, oa, la + $signed(28'($urandom_range(0, 4095)) - 28'sd2048),
                          oa + $signed(29'($urandom_range(0, 4095)) - 29'sd2048));
            else
                send_word(pick_lat(), pick_lon(), pick_lat(), pick_lon());
            la = pick_lat();
            oa = pick_lon();
        end
    endtask

    initial begin
        errors = 0; words_in = 0; words_out = 0; bad_seen = 0; radii_used = 0;
        radius_m = 23'd6371000;
        use_row_bad = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        dir_rows = '{
            '{28'sd0, 29'sd0, 28'sd0, 29'sd0, 1'b0},
            '{28'sd0, 29'sd0, 28'sd0, 29'(LON180), 1'b0},
            '{28'(LAT90), 29'sd0, 28'(-LAT90), 29'sd0, 1'b0},
            '{28'(LAT90), 29'(LON180), 28'(LAT90), 29'(-LON180), 1'b0},
            '{28'(LAT90 + 1), 29'sd0, 28'sd0, 29'sd0, 1'b1},
            '{28'sd0, 29'sd0, 28'(-LAT90 - 1), 29'sd0, 1'b1},
            '{28'sd0, 29'(LON180 + 1), 28'sd0, 29'sd0, 1'b1},
            '{28'sd0, 29'sd0, 28'sd0, 29'(-LON180 - 1), 1'b1},
            '{28'sd134217727, 29'sd0, 28'sd0, 29'sd0, 1'b1},
            '{28'sd0, 29'sd0, 28'(-134217728), 29'sd0, 1'b1},
            '{28'sd0, 29'sd268435455, 28'sd0, 29'sd0, 1'b1},
            '{28'sd0, 29'sd0, 28'sd0, 29'(-268435456), 1'b1},
            '{28'sd134217727, 29'sd268435455, 28'(-134217728), 29'(-268435456), 1'b1},
            '{-28'sd1, -29'sd1, -28'sd1, -29'sd1, 1'b0},
            '{28'sd40000000, 29'sd90000000, 28'sd40000000, 29'sd90000000, 1'b0},
            '{28'sd0, 29'(-179 << 20), 28'sd0, 29'(179 << 20), 1'b0},
            '{28'sd1000, 29'sd2000, 28'sd1001, 29'sd2000, 1'b0},
            '{28'sd53000000, -29'sd1500000, 28'sd42000000, 29'sd2300000, 1'b0},
            '{28'(-LAT90), 29'sd0, 28'(-LAT90), 29'sd100000000, 1'b0},
            '{28'sd0, 29'sd0, 28'sd0, 29'(LON180 - 1), 1'b0},
            '{28'(LAT90), 29'(LON180), 28'(-LAT90), 29'(-LON180), 1'b0},
            '{28'(-134217728), 29'(-268435456), 28'sd134217727, 29'sd268435455, 1'b1}
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at the reset radius, flag taken from the table
        use_row_bad = 1'b1;
        foreach (dir_rows[i]) row_bad_q.push_back(dir_rows[i].bad);
        foreach (dir_rows[i])
            send_word(dir_rows[i].lat_a, dir_rows[i].lon_a, dir_rows[i].lat_b,
                      dir_rows[i].lon_b);
        drain();
        use_row_bad = 1'b0;

        write_radius(23'd1);
        random_words(180);
        drain();
        write_radius(23'd8388607);
        random_words(250);
        drain();
        write_radius(23'd0);
        random_words(20);
        drain();
        write_radius(23'($urandom_range(1, 8388607)));
        random_words(250);
        drain();
        write_radius(23'd6371000);
        random_words(250);
        drain();

        $display("%0d words sent, %0d results checked, %0d flagged out of range",
                 words_in, words_out, bad_seen);
        $display("%0d radius settings including 0, 1, full scale and the reset value",
                 radii_used);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
